[rtl/rcz_pkg.sv]
// Package for the RGB 3x3 convolution unit with zero padding.
// Holds the shared constants, register indexes and the window entry type.
// No dependencies.
`timescale 1ns / 1ps

package rcz_pkg;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int COEFF_BITS_DEF = 16;

	localparam int PIX_W = 24;
	localparam int WIN_TAPS = 9;
	localparam int KREG_W = 48;
	localparam int IWIDTH_W = 12;
	localparam int IHEIGHT_W = 13;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

	localparam logic [IWIDTH_W-1:0] IMAGE_WIDTH_RST = 12'd2048;
	localparam logic [IHEIGHT_W-1:0] IMAGE_HEIGHT_RST = 13'd4096;
	localparam logic [KREG_W-1:0] KERNEL_TOP_RST = 48'd0;
	localparam logic [KREG_W-1:0] KERNEL_MIDDLE_RST = 48'd268435456;
	localparam logic [KREG_W-1:0] KERNEL_BOTTOM_RST = 48'd0;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	localparam int SAT_HI = 1044480;
	localparam int FRAC_BITS = 12;
	localparam logic [7:0] PIX_MAX = 8'd255;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// Taps are ordered column by column: left, center, right; top row first.
	typedef struct packed {
		logic [WIN_TAPS-1:0][PIX_W-1:0] px;
		logic last;
	} win_t;

endpackage

[rtl/rcz_queue.sv]
// Short transaction queue between the front and back parts of the convolution unit.
// Depends on rcz_pkg.
`timescale 1ns / 1ps

module rcz_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input rcz_pkg::win_t push_data,
	input logic pop,
	output rcz_pkg::win_t head,
	output logic empty,
	output logic [rcz_pkg::QCNT_W-1:0] count
);

	rcz_pkg::win_t slot_q [rcz_pkg::QDEPTH];
	logic [rcz_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [rcz_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [rcz_pkg::QCNT_W-1:0] count_q;

	assign head = slot_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q != rcz_pkg::QCNT_W'(rcz_pkg::QDEPTH))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rcz_pkg::QCNT_W'(rcz_pkg::QDEPTH))
		else $error("queue count out of range");
`endif

endmodule

[rtl/rcz_front.sv]
// Front part of the convolution unit: accepts pixels, tracks row and column,
// keeps the two line stores and the window, and queues each window to filter.
// Depends on rcz_pkg.
`timescale 1ns / 1ps

module rcz_front #(
	parameter int MAX_WIDTH = rcz_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rcz_pkg::MAX_HEIGHT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic pix_valid,
	output logic pix_ready,
	input logic req_type,
	input logic [7:0] pixel_red,
	input logic [7:0] pixel_green,
	input logic [7:0] pixel_blue,
	input logic [rcz_pkg::IWIDTH_W-1:0] image_width,
	input logic [rcz_pkg::IHEIGHT_W-1:0] image_height,
	input logic [rcz_pkg::QCNT_W-1:0] q_count,
	output logic push,
	output rcz_pkg::win_t push_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 2);
	localparam int PW = rcz_pkg::PIX_W;

	logic [PW-1:0] up_mem [MAX_WIDTH];
	logic [PW-1:0] lo_mem [MAX_WIDTH];

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [PW-1:0] rd_up_q;
	logic [PW-1:0] rd_lo_q;
	logic [5:0][PW-1:0] win_q;

	logic valid_s1;
	logic [CW-1:0] c_s1;
	logic c0_s1;
	logic close_s1;
	logic emit0_s1;
	logic top_ok_s1;
	logic mid_ok_s1;
	logic [PW-1:0] p_s1;

	logic accept;
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [RW-1:0] h1;
	logic wrap;
	logic [CW-1:0] c;
	logic [RW-1:0] r;
	logic c0;
	logic close;
	logic [WW-1:0] c_inc;
	logic [PW-1:0] p;
	logic [PW-1:0] nc0;
	logic [PW-1:0] nc1;

	always_comb begin
		if (32'(image_width) < 32'd2) begin
			w_eff = WW'(2);
		end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(image_width);
		end
		if (32'(image_height) < 32'd2) begin
			h_eff = HW'(2);
		end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(image_height);
		end
	end

	assign h1 = RW'(h_eff) + RW'(1);
	assign pix_ready = (32'(q_count) + 32'(valid_s1)) < 32'(rcz_pkg::QDEPTH);
	assign accept = pix_valid && pix_ready;

	assign wrap = WW'(col_q) >= w_eff;
	assign c = wrap ? '0 : col_q;
	assign r = wrap ? row_q + RW'(1) : row_q;
	assign c0 = (c == '0);
	assign close = c0 && (r >= h1);
	assign c_inc = WW'(c) + WW'(1);

	always_comb begin
		if (req_type == rcz_pkg::REQ_DRAIN || r >= RW'(h_eff)) begin
			p = '0;
		end else begin
			p = {pixel_blue, pixel_green, pixel_red};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (close) begin
					col_q <= '0;
					row_q <= '0;
				end else if (c_inc >= w_eff) begin
					col_q <= '0;
					row_q <= r + RW'(1);
				end else begin
					col_q <= CW'(c_inc);
					row_q <= r;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1 <= c;
			c0_s1 <= c0;
			close_s1 <= close;
			emit0_s1 <= c0 && (r >= RW'(2));
			top_ok_s1 <= r >= RW'(2);
			mid_ok_s1 <= r >= RW'(1);
			p_s1 <= p;
			rd_up_q <= up_mem[c];
			rd_lo_q <= lo_mem[c];
		end
		if (valid_s1 && !close_s1) begin
			up_mem[c_s1] <= nc1;
			lo_mem[c_s1] <= p_s1;
		end
	end

	assign nc0 = top_ok_s1 ? rd_up_q : '0;
	assign nc1 = mid_ok_s1 ? rd_lo_q : '0;

	assign push = valid_s1 && (emit0_s1 || (!c0_s1 && mid_ok_s1));

	always_comb begin
		push_data.px[0] = win_q[0];
		push_data.px[1] = win_q[1];
		push_data.px[2] = win_q[2];
		push_data.px[3] = win_q[3];
		push_data.px[4] = win_q[4];
		push_data.px[5] = win_q[5];
		push_data.px[6] = emit0_s1 ? '0 : nc0;
		push_data.px[7] = emit0_s1 ? '0 : nc1;
		push_data.px[8] = emit0_s1 ? '0 : p_s1;
		push_data.last = close_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (valid_s1) begin
			if (close_s1) begin
				win_q <= '0;
			end else begin
				win_q[0] <= c0_s1 ? '0 : win_q[3];
				win_q[1] <= c0_s1 ? '0 : win_q[4];
				win_q[2] <= c0_s1 ? '0 : win_q[5];
				win_q[3] <= nc0;
				win_q[4] <= nc1;
				win_q[5] <= p_s1;
			end
		end
	end

endmodule

[rtl/rcz_back.sv]
// Back part of the convolution unit: multiplies each window by the kernel,
// sums per channel, clamps and holds the result in the output register.
// Depends on rcz_pkg.
`timescale 1ns / 1ps

module rcz_back #(
	parameter int COEFF_BITS = rcz_pkg::COEFF_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input rcz_pkg::win_t head,
	input logic empty,
	output logic pop,
	input logic [rcz_pkg::KREG_W-1:0] kernel_top_row,
	input logic [rcz_pkg::KREG_W-1:0] kernel_middle_row,
	input logic [rcz_pkg::KREG_W-1:0] kernel_bottom_row,
	output logic res_valid,
	input logic res_ready,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	output logic frame_last
);

	localparam int CB = COEFF_BITS;
	localparam int KPW = rcz_pkg::KREG_W + 3 * CB;
	localparam int PRW = CB + 9;
	localparam int RSW = CB + 11;
	localparam int SW = CB + 14;
	localparam int FB = rcz_pkg::FRAC_BITS;

	logic [2:0][KPW-1:0] kpad;
	logic signed [2:0][2:0][CB-1:0] coef;

	logic valid_s1;
	logic last_s1;
	logic signed [PRW-1:0] prod_s1 [3][9];
	logic valid_s2;
	logic last_s2;
	logic signed [RSW-1:0] rsum_s2 [3][3];

	logic adv;
	logic signed [SW-1:0] total [3];
	logic [7:0] clamped [3];
	logic signed [SW-1:0] sat_lim;

	assign kpad[0] = {(3 * CB)'(0), kernel_top_row};
	assign kpad[1] = {(3 * CB)'(0), kernel_middle_row};
	assign kpad[2] = {(3 * CB)'(0), kernel_bottom_row};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				coef[i][j] = kpad[i][j * CB +: CB];
			end
		end
	end

	assign adv = !res_valid || res_ready;
	assign pop = adv && !empty;
	assign sat_lim = SW'(rcz_pkg::SAT_HI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			res_valid <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			res_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= head.last;
			for (int ch = 0; ch < 3; ch++) begin
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						prod_s1[ch][i * 3 + j] <= $signed(coef[i][j])
							* $signed({1'b0, head.px[j * 3 + i][ch * 8 +: 8]});
					end
				end
			end
			last_s2 <= last_s1;
			for (int ch = 0; ch < 3; ch++) begin
				for (int i = 0; i < 3; i++) begin
					rsum_s2[ch][i] <= RSW'(prod_s1[ch][i * 3])
						+ RSW'(prod_s1[ch][i * 3 + 1]) + RSW'(prod_s1[ch][i * 3 + 2]);
				end
			end
			frame_last <= last_s2;
			out_red <= clamped[0];
			out_green <= clamped[1];
			out_blue <= clamped[2];
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			total[ch] = SW'(rsum_s2[ch][0]) + SW'(rsum_s2[ch][1]) + SW'(rsum_s2[ch][2]);
			if (total[ch] < 0) begin
				clamped[ch] = '0;
			end else if (total[ch] > sat_lim) begin
				clamped[ch] = rcz_pkg::PIX_MAX;
			end else begin
				clamped[ch] = total[ch][FB +: 8];
			end
		end
	end

endmodule

[rtl/rgb_conv3x3_zero_pad_unit.sv]
// Streaming 3x3 convolution of RGB pixels in raster order; top level with the register file.
// Instantiates rcz_front, rcz_queue and rcz_back; depends on rcz_pkg.
//
// The unit takes one pixel or drain transaction per clock while pix_ready is high and applies
// one signed Q12 kernel to each color, treating pixels outside the image as zero and clamping
// each result to 0..255. A result appears for the transaction one row and one pixel later;
// after the last row, width plus one drain transactions flush the bottom row, and frame_last
// marks its final pixel. Line stores are read at the accepting edge; stores, window and queue
// are written in the cycle after; the multiply, row-sum and clamp stages of the back part are
// registered and stall while a result waits; a four-entry queue between the halves absorbs
// output stalls, so with res_ready high the sustained rate is one transaction per clock.
// Write the registers only while the unit is idle.
`timescale 1ns / 1ps

module rgb_conv3x3_zero_pad_unit #(
	parameter int MAX_WIDTH = rcz_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rcz_pkg::MAX_HEIGHT_DEF,
	parameter int COEFF_BITS = rcz_pkg::COEFF_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [rcz_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [rcz_pkg::KREG_W-1:0] cfg_data,
	input logic pix_valid,
	output logic pix_ready,
	input logic req_type,
	input logic [7:0] pixel_red,
	input logic [7:0] pixel_green,
	input logic [7:0] pixel_blue,
	output logic res_valid,
	input logic res_ready,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	output logic frame_last
);

	logic [rcz_pkg::IWIDTH_W-1:0] image_width_q;
	logic [rcz_pkg::IHEIGHT_W-1:0] image_height_q;
	logic [rcz_pkg::KREG_W-1:0] kernel_top_q;
	logic [rcz_pkg::KREG_W-1:0] kernel_middle_q;
	logic [rcz_pkg::KREG_W-1:0] kernel_bottom_q;

	logic push;
	rcz_pkg::win_t push_data;
	logic pop;
	rcz_pkg::win_t head;
	logic empty;
	logic [rcz_pkg::QCNT_W-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= rcz_pkg::IMAGE_WIDTH_RST;
			image_height_q <= rcz_pkg::IMAGE_HEIGHT_RST;
			kernel_top_q <= rcz_pkg::KERNEL_TOP_RST;
			kernel_middle_q <= rcz_pkg::KERNEL_MIDDLE_RST;
			kernel_bottom_q <= rcz_pkg::KERNEL_BOTTOM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rcz_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data[rcz_pkg::IWIDTH_W-1:0];
				end
				rcz_pkg::REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data[rcz_pkg::IHEIGHT_W-1:0];
				end
				rcz_pkg::REG_KERNEL_TOP: begin
					kernel_top_q <= cfg_data;
				end
				rcz_pkg::REG_KERNEL_MIDDLE: begin
					kernel_middle_q <= cfg_data;
				end
				rcz_pkg::REG_KERNEL_BOTTOM: begin
					kernel_bottom_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	rcz_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.req_type(req_type),
		.pixel_red(pixel_red),
		.pixel_green(pixel_green),
		.pixel_blue(pixel_blue),
		.image_width(image_width_q),
		.image_height(image_height_q),
		.q_count(q_count),
		.push(push),
		.push_data(push_data)
	);

	rcz_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.head(head),
		.empty(empty),
		.count(q_count)
	);

	rcz_back #(
		.COEFF_BITS(COEFF_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.pop(pop),
		.kernel_top_row(kernel_top_q),
		.kernel_middle_row(kernel_middle_q),
		.kernel_bottom_row(kernel_bottom_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue),
		.frame_last(frame_last)
	);

endmodule
